@@ rtl/bta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types and constants of the block table allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned IdxW         = 8;    // log2(TableEntries)
  localparam int unsigned CntW         = 9;    // holds 0..TableEntries
  localparam int unsigned BlockShift   = 5;    // log2(block bytes)
  localparam int unsigned OffW         = IdxW + BlockShift;
  localparam int unsigned NeedW        = 16 - BlockShift + 1;

  localparam logic [1:0] KindAlloc = 2'd0;
  localparam logic [1:0] KindFree  = 2'd1;
  localparam logic [1:0] KindClear = 2'd2;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StNoRoom = 2'd1;
  localparam logic [1:0] StRange  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] size_bytes;
    logic [15:0] offset_bytes;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [OffW-1:0] alloc_offset;
    logic [CntW-1:0] used_blocks;
    logic [6:0]      usage_percent;
  } rsp_t;

  typedef struct packed {
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [CntW-1:0] wr_data;
    logic            clr;
  } tbl_cmd_t;

endpackage

@@ rtl/bta_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_table
// Run-length table: one synchronous memory with registered read data and a
// valid flag per entry, so that a reset or clear empties all entries together.
// ----------------------------------------------------------------------------
module bta_table (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bta_pkg::tbl_cmd_t        cmd_i,
  output logic [bta_pkg::CntW-1:0] rd_data_o
);
  import bta_pkg::*;

  logic [CntW-1:0]         mem_q [TableEntries];
  logic [CntW-1:0]         rdata_q;
  logic [TableEntries-1:0] valid_q;
  logic                    rvld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= cmd_i.wr_data;
    end
    rdata_q <= mem_q[cmd_i.rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      rvld_q <= valid_q[cmd_i.rd_addr];
      if (cmd_i.clr) begin
        valid_q <= '0;
      end else if (cmd_i.wr_en) begin
        valid_q[cmd_i.wr_addr] <= 1'b1;
      end
    end
  end

  // An entry never written since the last clear reads as free.
  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

@@ rtl/block_table_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_table_allocator
// Block table allocator: allocate and free runs of pool blocks, or clear all.
// ----------------------------------------------------------------------------
// An allocate scans the table downward from the top entry, then marks the run;
// a free clears the run from its head upward; clear and rejects respond directly.
// Throughput: one item at a time; the table memory is read one entry a cycle.
// Reset: the table is empty at once through per-entry valid flags.
// The result beat is shown for one cycle on done_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
module block_table_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bta_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output bta_pkg::rsp_t rsp_o
);
  import bta_pkg::*;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StScan  = 5'b00010,
    StMark  = 5'b00100,
    StFree  = 5'b01000,
    StResp  = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] k_q, k_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] need_q, need_d;
  logic [CntW-1:0] run_q, run_d;
  logic [CntW-1:0] used_q, used_d;
  logic [1:0]      status_q, status_d;
  logic [OffW-1:0] aoff_q, aoff_d;

  tbl_cmd_t        cmd;
  logic [CntW-1:0] rd_data;

  logic [16:0]      size_sum;
  logic [NeedW-1:0] need_full;
  logic [CntW-1:0]  run_n;
  logic [CntW-1:0]  cnt_eff;
  logic [15:0]      pct_full;

  bta_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_data_o (rd_data)
  );

  assign size_sum  = {1'b0, req_i.size_bytes} + 17'((1 << BlockShift) - 1);
  assign need_full = size_sum[16:BlockShift];
  assign run_n     = (rd_data == '0) ? run_q + 1'b1 : '0;
  assign cnt_eff   = (k_q == '0) ? rd_data : cnt_q;

  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    k_d      = k_q;
    cnt_d    = cnt_q;
    need_d   = need_q;
    run_d    = run_q;
    used_d   = used_q;
    status_d = status_q;
    aoff_d   = aoff_q;
    cmd      = '0;
    cmd.rd_addr = ptr_q;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          status_d = StOk;
          aoff_d   = '0;
          k_d      = '0;
          run_d    = '0;
          state_d  = StResp;
          priority if (req_i.kind == KindAlloc) begin
            if (req_i.size_bytes == '0 ||
                need_full > NeedW'(TableEntries)) begin
              status_d = StNoRoom;
            end else begin
              need_d      = need_full[CntW-1:0];
              ptr_d       = IdxW'(TableEntries - 1);
              cmd.rd_addr = IdxW'(TableEntries - 1);
              state_d     = StScan;
            end
          end else if (req_i.kind == KindFree) begin
            if (req_i.offset_bytes[15:OffW] != '0) begin
              status_d = StRange;
            end else begin
              ptr_d       = req_i.offset_bytes[OffW-1:BlockShift];
              cmd.rd_addr = req_i.offset_bytes[OffW-1:BlockShift];
              state_d     = StFree;
            end
          end else if (req_i.kind == KindClear) begin
            cmd.clr = 1'b1;
            used_d  = '0;
          end else begin
            // Unused kind: report counters unchanged.
          end
        end
      end

      StScan: begin
        // Data for ptr_q is here; read the next entry down.
        cmd.rd_addr = ptr_q - 1'b1;
        run_d       = run_n;
        if (run_n == need_q) begin
          aoff_d  = {ptr_q, {BlockShift{1'b0}}};
          used_d  = used_q + need_q;
          k_d     = '0;
          state_d = StMark;
        end else if (ptr_q == '0) begin
          status_d = StNoRoom;
          state_d  = StResp;
        end else begin
          ptr_d = ptr_q - 1'b1;
        end
      end

      StMark: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = ptr_q;
        cmd.wr_data = need_q;
        ptr_d       = ptr_q + 1'b1;
        k_d         = k_q + 1'b1;
        if (k_q + 1'b1 == need_q) begin
          state_d = StResp;
        end
      end

      StFree: begin
        // The head entry gives the count; clear from there upward.
        cmd.rd_addr = ptr_q + 1'b1;
        if (k_q == '0) begin
          cnt_d = rd_data;
        end
        if (rd_data != '0 && k_q < cnt_eff) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = ptr_q;
          cmd.wr_data = '0;
          used_d      = used_q - 1'b1;
        end
        if (({1'b0, k_q} + 1'b1 >= {1'b0, cnt_eff}) ||
            ptr_q == IdxW'(TableEntries - 1)) begin
          state_d = StResp;
        end else begin
          k_d   = k_q + 1'b1;
          ptr_d = ptr_q + 1'b1;
        end
      end

      StResp: begin
        state_d = StIdle;
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      used_q   <= '0;
      ptr_q    <= '0;
      k_q      <= '0;
      cnt_q    <= '0;
      need_q   <= '0;
      run_q    <= '0;
      status_q <= StOk;
      aoff_q   <= '0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      ptr_q    <= ptr_d;
      k_q      <= k_d;
      cnt_q    <= cnt_d;
      need_q   <= need_d;
      run_q    <= run_d;
      status_q <= status_d;
      aoff_q   <= aoff_d;
    end
  end

  // used * 100 / 256
  assign pct_full = 16'(used_q) * 16'd100;

  assign busy_o              = (state_q != StIdle);
  assign done_o              = (state_q == StResp);
  assign rsp_o.status        = status_q;
  assign rsp_o.alloc_offset  = aoff_q;
  assign rsp_o.used_blocks   = used_q;
  assign rsp_o.usage_percent = pct_full[14:8];

endmodule
